### rtl/proximity_sensor_change_reporter_top_defines.svh
// ----------------------------------------------------------------------------
// Proximity sensor change reporter: assertion macros
// Shared assertion forms for the reporter modules; clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_SENSOR_CHANGE_REPORTER_TOP_DEFINES_SVH
`define PROXIMITY_SENSOR_CHANGE_REPORTER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define PSCR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define PSCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pscr_pkg.sv
// ----------------------------------------------------------------------------
// Proximity sensor change reporter: package
// Types, constants and the channel id table shared by the reporter modules.
// ----------------------------------------------------------------------------
package pscr_pkg;

	localparam int NUM_CHAN    = 10;
	localparam int NUM_LIGHT   = 6;
	localparam int NUM_CLIFF   = 4;
	localparam int LEVEL_W     = 12;
	localparam int ID_W        = 4;
	localparam int PERIOD_W    = 8;
	localparam int CHAN_IDX_W  = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEVEL_W-1:0]  THRESH_RST = 12'd2800;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd10;
	localparam logic [PERIOD_W-1:0] COUNT_MAX  = 8'd255;

	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [NUM_CHAN-1:0] mask_t;
	typedef logic [ID_W-1:0]     report_id_t;

	typedef enum logic [0:0] {
		REG_LIGHT_THRESHOLD = 1'b0,
		REG_REPORT_PERIOD   = 1'b1
	} cfg_reg_t;

	// One pending report: active channels and the frame's levels
	typedef struct packed {
		mask_t                      mask;
		logic [NUM_CHAN-1:0][LEVEL_W-1:0] level;
	} pscr_entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} pscr_qstat_t;

	// Channel position to reported id
	function automatic report_id_t chan_id(input logic [CHAN_IDX_W-1:0] idx);
		report_id_t id;
		unique case (idx)
			4'd0:    id = 4'd4;
			4'd1:    id = 4'd2;
			4'd2:    id = 4'd1;
			4'd3:    id = 4'd6;
			4'd4:    id = 4'd3;
			4'd5:    id = 4'd5;
			4'd6:    id = 4'd7;
			4'd7:    id = 4'd8;
			4'd8:    id = 4'd9;
			4'd9:    id = 4'd10;
			default: id = '0;
		endcase
		return id;
	endfunction

endpackage

### rtl/proximity_sensor_change_reporter_top.sv
// ----------------------------------------------------------------------------
// Proximity sensor change reporter: top level
// Reports the active proximity channels of a frame when the set changes or
// when an unchanged, nonempty set has gone unreported for a whole period.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Contents
//  -------   --------------------   -------------------------------------------
//  in        in_valid / in_stall    one frame: ten levels and four cliff flags
//  out       out_valid / out_stall  one active channel: id, level, last marker
//  cfg       cfg_we                 cfg_index selects threshold or period
//
//  The front end takes one frame per cycle while the two-entry report queue
//  has room; frames that raise no report never enter the queue.
//  The back end delivers one result per cycle unless the output stalls; a
//  report's walk over its k active channels (one to ten) sets the rate.
//  A stalled output request holds in the output register while the back end
//  waits; in_stall rises only when the queue is full.
//  Reset is asynchronous and active low; no clearing pass is needed.
//
module proximity_sensor_change_reporter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pscr_pkg::level_t    light_left,
	input  pscr_pkg::level_t    light_front_left,
	input  pscr_pkg::level_t    light_center_left,
	input  pscr_pkg::level_t    light_center_right,
	input  pscr_pkg::level_t    light_front_right,
	input  pscr_pkg::level_t    light_right,
	input  pscr_pkg::level_t    cliff_left_level,
	input  pscr_pkg::level_t    cliff_front_left_level,
	input  pscr_pkg::level_t    cliff_front_right_level,
	input  pscr_pkg::level_t    cliff_right_level,
	input  logic [3:0]          cliff_flags,
	output logic                out_valid,
	input  logic                out_stall,
	output pscr_pkg::report_id_t report_id,
	output pscr_pkg::level_t    sensor_level,
	output logic                last_of_run,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  pscr_pkg::level_t    cfg_data
);
	import pscr_pkg::*;

	// Queue handshake between the two halves
	logic        push;
	logic        pop;
	pscr_entry_t push_entry;
	pscr_entry_t pop_entry;
	pscr_qstat_t qstat;

	// Classify frames and hold the report state
	pscr_front u_front (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.light_left              (light_left),
		.light_front_left        (light_front_left),
		.light_center_left       (light_center_left),
		.light_center_right      (light_center_right),
		.light_front_right       (light_front_right),
		.light_right             (light_right),
		.cliff_left_level        (cliff_left_level),
		.cliff_front_left_level  (cliff_front_left_level),
		.cliff_front_right_level (cliff_front_right_level),
		.cliff_right_level       (cliff_right_level),
		.cliff_flags             (cliff_flags),
		.cfg_we                  (cfg_we),
		.cfg_index               (cfg_index),
		.cfg_data                (cfg_data),
		.qstat                   (qstat),
		.push                    (push),
		.push_entry              (push_entry)
	);

	// Decouple the sides: hold pending reports
	pscr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	// Advance through the active channels and drive the output requests
	pscr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.report_id    (report_id),
		.sensor_level (sensor_level),
		.last_of_run  (last_of_run)
	);

endmodule

### rtl/pscr_front.sv
// ----------------------------------------------------------------------------
// Proximity sensor change reporter: front end
// Accepts frames, builds the active mask, decides on a report and queues it.
// ----------------------------------------------------------------------------
module pscr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pscr_pkg::level_t     light_left,
	input  pscr_pkg::level_t     light_front_left,
	input  pscr_pkg::level_t     light_center_left,
	input  pscr_pkg::level_t     light_center_right,
	input  pscr_pkg::level_t     light_front_right,
	input  pscr_pkg::level_t     light_right,
	input  pscr_pkg::level_t     cliff_left_level,
	input  pscr_pkg::level_t     cliff_front_left_level,
	input  pscr_pkg::level_t     cliff_front_right_level,
	input  pscr_pkg::level_t     cliff_right_level,
	input  logic [3:0]           cliff_flags,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  pscr_pkg::level_t     cfg_data,
	input  pscr_pkg::pscr_qstat_t qstat,
	output logic                 push,
	output pscr_pkg::pscr_entry_t push_entry
);
	import pscr_pkg::*;

	level_t                threshold_q;
	logic [PERIOD_W-1:0]   period_q;
	mask_t                 reported_mask_q;
	logic [PERIOD_W-1:0]   count_q;
	logic [PERIOD_W-1:0]   count_inc;
	level_t [NUM_CHAN-1:0] level;
	mask_t                 mask;
	logic                  accept;
	logic                  report;

	assign level[0] = light_left;
	assign level[1] = light_front_left;
	assign level[2] = light_center_left;
	assign level[3] = light_center_right;
	assign level[4] = light_front_right;
	assign level[5] = light_right;
	assign level[6] = cliff_left_level;
	assign level[7] = cliff_front_left_level;
	assign level[8] = cliff_front_right_level;
	assign level[9] = cliff_right_level;

	always_comb begin
		mask = '0;
		for (int i = 0; i < NUM_LIGHT; i++) begin
			mask[i] = level[i] > threshold_q;
		end
		mask[NUM_CHAN-1:NUM_LIGHT] = cliff_flags;
	end

	// Saturating frame count, tested after the increment
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign report    = (mask != reported_mask_q) ||
	                   ((mask != '0) && (count_inc >= period_q));

	assign in_stall        = qstat.full;
	assign accept          = in_valid && !qstat.full;
	assign push            = accept && report && (mask != '0);
	assign push_entry.mask  = mask;
	assign push_entry.level = level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			reported_mask_q <= '0;
		end else if (accept) begin
			if (report) begin
				count_q         <= '0;
				reported_mask_q <= mask;
			end else begin
				count_q <= count_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RST;
			period_q    <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LIGHT_THRESHOLD: threshold_q <= cfg_data;
				REG_REPORT_PERIOD:   period_q    <= cfg_data[PERIOD_W-1:0];
			endcase
		end
	end

endmodule

### rtl/pscr_queue.sv
// ----------------------------------------------------------------------------
// Proximity sensor change reporter: report queue
// Short first-in first-out store of pending reports between front and back.
// ----------------------------------------------------------------------------
`include "proximity_sensor_change_reporter_top_defines.svh"

module pscr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pscr_pkg::pscr_entry_t push_entry,
	input  logic                  pop,
	output pscr_pkg::pscr_entry_t pop_entry,
	output pscr_pkg::pscr_qstat_t qstat
);
	import pscr_pkg::*;

	pscr_entry_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign qstat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PSCR_ASSERT_NOW(a_no_overflow, push && !pop, !qstat.full, "push into a full queue")
	`PSCR_ASSERT_NOW(a_no_underflow, pop, !qstat.empty, "pop from an empty queue")
	`PSCR_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

### rtl/pscr_back.sv
// ----------------------------------------------------------------------------
// Proximity sensor change reporter: back end
// Walks a queued report's active channels, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "proximity_sensor_change_reporter_top_defines.svh"

module pscr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pscr_pkg::pscr_qstat_t qstat,
	input  pscr_pkg::pscr_entry_t pop_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pscr_pkg::report_id_t  report_id,
	output pscr_pkg::level_t      sensor_level,
	output logic                  last_of_run
);
	import pscr_pkg::*;

	mask_t                    cur_mask_q;
	level_t [NUM_CHAN-1:0]    cur_level_q;
	logic                     out_valid_q;
	report_id_t               report_id_q;
	level_t                   sensor_level_q;
	logic                     last_q;
	logic [CHAN_IDX_W-1:0]    idx;
	mask_t                    remaining;
	logic                     has_work;
	logic                     out_load;
	logic                     drain;

	// Lowest active channel goes first
	always_comb begin
		idx = '0;
		for (int i = NUM_CHAN - 1; i >= 0; i--) begin
			if (cur_mask_q[i]) begin
				idx = CHAN_IDX_W'(i);
			end
		end
	end

	assign remaining = cur_mask_q & (cur_mask_q - 1'b1);
	assign has_work  = cur_mask_q != '0;
	assign out_load  = has_work && (!out_valid_q || !out_stall);
	assign drain     = !has_work || (out_load && (remaining == '0));
	assign pop       = drain && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_mask_q <= pop_entry.mask;
			end else if (out_load) begin
				cur_mask_q <= remaining;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_level_q <= pop_entry.level;
		end
		if (out_load) begin
			report_id_q    <= chan_id(idx);
			sensor_level_q <= cur_level_q[idx];
			last_q         <= remaining == '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign report_id    = report_id_q;
	assign sensor_level = sensor_level_q;
	assign last_of_run  = last_q;

	`PSCR_ASSERT_NOW(a_id_range, out_valid_q, (report_id_q != '0) && (report_id_q <= 4'd10), "id out of range")
	`PSCR_ASSERT_NOW(a_pop_when_idle, pop, drain, "report taken while one is still in flight")
	`PSCR_ASSERT_NEXT(a_mask_shrinks, out_load && !pop, cur_mask_q == $past(remaining), "channel not retired")

endmodule
